FILE: rtl/clhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clhc_pkg
// Shared types, level codes and the airtime factor lookup for the congestion
// level hysteresis controller.
// ----------------------------------------------------------------------------
package clhc_pkg;

   // congestion levels
   localparam logic [1:0] LVL_NORMAL    = 2'd0;
   localparam logic [1:0] LVL_BUSY      = 2'd1;
   localparam logic [1:0] LVL_CONGESTED = 2'd2;
   localparam logic [1:0] LVL_SEVERE    = 2'd3;

   // register indexes on the csr port
   localparam logic [2:0] REG_SEVERE_FREE     = 3'd0;
   localparam logic [2:0] REG_CONGESTED_FREE  = 3'd1;
   localparam logic [2:0] REG_BUSY_FREE       = 3'd2;
   localparam logic [2:0] REG_SEVERE_QUEUE    = 3'd3;
   localparam logic [2:0] REG_CONGESTED_QUEUE = 3'd4;
   localparam logic [2:0] REG_BUSY_QUEUE      = 3'd5;
   localparam logic [2:0] REG_CHECK_INTERVAL  = 3'd6;
   localparam logic [2:0] REG_RECOVERY_QUIET  = 3'd7;

   // register reset values
   localparam logic [7:0]  RST_SEVERE_FREE     = 8'd6;
   localparam logic [7:0]  RST_CONGESTED_FREE  = 8'd10;
   localparam logic [7:0]  RST_BUSY_FREE       = 8'd16;
   localparam logic [7:0]  RST_SEVERE_QUEUE    = 8'd24;
   localparam logic [7:0]  RST_CONGESTED_QUEUE = 8'd16;
   localparam logic [7:0]  RST_BUSY_QUEUE      = 8'd8;
   localparam logic [15:0] RST_CHECK_INTERVAL  = 16'd5000;
   localparam logic [3:0]  RST_RECOVERY_QUIET  = 4'd6;

   typedef struct packed {
      logic [7:0]  severe_free_limit;
      logic [7:0]  congested_free_limit;
      logic [7:0]  busy_free_limit;
      logic [7:0]  severe_queue_limit;
      logic [7:0]  congested_queue_limit;
      logic [7:0]  busy_queue_limit;
      logic [15:0] check_interval_ms;
      logic [3:0]  recovery_quiet_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [7:0]  free_buffers;
      logic [7:0]  tx_depth;
      logic [7:0]  rx_depth;
      logic [31:0] tx_drops;
      logic [31:0] rx_drops;
   } sample_type;

   typedef struct packed {
      logic [1:0]  current_level;
      logic [3:0]  quiet_count;
      logic [31:0] previous_drop_sum;
      logic [31:0] next_check_time;
   } state_type;

   // duty factor by level
   function automatic logic [6:0] duty_factor(input logic [1:0] lvl);
      logic [6:0] f;
      case (lvl)
         LVL_NORMAL:    f = 7'd9;
         LVL_BUSY:      f = 7'd19;
         LVL_CONGESTED: f = 7'd49;
         LVL_SEVERE:    f = 7'd99;
         default:       f = 7'd9;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/congestion_level_hysteresis_controller_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// congestion_level_hysteresis_controller_top
// Periodic congestion classifier with rise-at-once, fall-slowly hysteresis.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    status sample word (120 bits used)
//  rsp      out        rsp_tvalid/tready    level, cad enable, airtime factor
//  csr      in         csr_valid/ready      register index and write data
//
// a sample is taken into an input register, evaluated there by short logic
// and, when due, its result lands in the output register
// one word per cycle sustained while rsp_tready stays high
// samples that are not due leave the input register without a result word
// a due sample waits in the input register while the output register is full
// and not being taken; req_tready drops only in that case
// reset loads the register defaults, clears the level, quiet count and drop sum
// and sets the next check time to the default interval
//
module congestion_level_hysteresis_controller_top
   import clhc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,

   input  wire          req_tvalid,
   output logic         req_tready,
   // [31:0] now_ms, [39:32] free_buffers, [47:40] tx_depth,
   // [55:48] rx_depth, [87:56] tx_drops, [119:88] rx_drops
   input  wire  [119:0] req_tdata,

   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [1:0] level, [2] cad_enable, [9:3] duty factor, rest zero
   output logic [15:0]  rsp_tdata,

   input  wire          csr_valid,
   output logic         csr_ready,
   input  wire  [2:0]   csr_index,
   input  wire  [15:0]  csr_data
);

   // input register
   sample_type s1_ff, s1_in;
   logic       s1_valid_ff, s1_valid_in;

   // config and hysteresis state
   cfg_type    cfg_ff, cfg_in;
   state_type  state_ff, state_in, state_nxt;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_level_ff, rsp_level_in;

   logic       due;
   logic       adv;
   logic       eval;
   logic       req_take;

   clhc_eval u_eval (
      .smp (s1_ff),
      .cfg (cfg_ff),
      .cur (state_ff),
      .due (due),
      .nxt (state_nxt)
   );

   // the sample leaves the input register when it gives no word or the
   // output register has room this cycle
   assign adv        = s1_valid_ff & (~due | ~rsp_valid_ff | rsp_tready);
   assign eval       = adv & due;
   assign req_tready = ~s1_valid_ff | adv;
   assign req_take   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_in = s1_ff;
      if (req_take) begin
         s1_in.now_ms       = req_tdata[31:0];
         s1_in.free_buffers = req_tdata[39:32];
         s1_in.tx_depth     = req_tdata[47:40];
         s1_in.rx_depth     = req_tdata[55:48];
         s1_in.tx_drops     = req_tdata[87:56];
         s1_in.rx_drops     = req_tdata[119:88];
      end
      s1_valid_in = req_take ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);

      state_in = eval ? state_nxt : state_ff;

      rsp_level_in = eval ? state_nxt.current_level : rsp_level_ff;
      rsp_valid_in = eval ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      // register writes leave the next check time alone
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_SEVERE_FREE:     cfg_in.severe_free_limit     = csr_data[7:0];
            REG_CONGESTED_FREE:  cfg_in.congested_free_limit  = csr_data[7:0];
            REG_BUSY_FREE:       cfg_in.busy_free_limit       = csr_data[7:0];
            REG_SEVERE_QUEUE:    cfg_in.severe_queue_limit    = csr_data[7:0];
            REG_CONGESTED_QUEUE: cfg_in.congested_queue_limit = csr_data[7:0];
            REG_BUSY_QUEUE:      cfg_in.busy_queue_limit      = csr_data[7:0];
            REG_CHECK_INTERVAL:  cfg_in.check_interval_ms     = csr_data;
            REG_RECOVERY_QUIET:  cfg_in.recovery_quiet_count  = csr_data[3:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      rsp_level_ff <= rsp_level_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff                    <= 1'b0;
         rsp_valid_ff                   <= 1'b0;
         cfg_ff.severe_free_limit       <= RST_SEVERE_FREE;
         cfg_ff.congested_free_limit    <= RST_CONGESTED_FREE;
         cfg_ff.busy_free_limit         <= RST_BUSY_FREE;
         cfg_ff.severe_queue_limit      <= RST_SEVERE_QUEUE;
         cfg_ff.congested_queue_limit   <= RST_CONGESTED_QUEUE;
         cfg_ff.busy_queue_limit        <= RST_BUSY_QUEUE;
         cfg_ff.check_interval_ms       <= RST_CHECK_INTERVAL;
         cfg_ff.recovery_quiet_count    <= RST_RECOVERY_QUIET;
         state_ff.current_level         <= LVL_NORMAL;
         state_ff.quiet_count           <= 4'd0;
         state_ff.previous_drop_sum     <= 32'd0;
         state_ff.next_check_time       <= {16'd0, RST_CHECK_INTERVAL};
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
      end
   end

   // cad enable and airtime factor follow from the registered level
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, duty_factor(rsp_level_ff),
                        (rsp_level_ff != LVL_NORMAL), rsp_level_ff};

   // the level never falls by more than one step per evaluation
   a_fall_one_step : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (state_ff.current_level < $past(state_ff.current_level)))
         |-> (state_ff.current_level == $past(state_ff.current_level) - 2'd1))
      else $error("level fell by more than one step");

   // hysteresis state moves only on an evaluated sample
   a_state_on_eval : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(eval)) |-> $stable(state_ff))
      else $error("state changed without an evaluation");

   // a new result word appears only after an evaluation
   a_rsp_from_eval : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(eval))
      else $error("result word without evaluation");

endmodule
`default_nettype wire

FILE: rtl/clhc_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clhc_eval
// Due test, sample classification and level hysteresis for one sample.
// ----------------------------------------------------------------------------
module clhc_eval
   import clhc_pkg::*;
(
   input  wire sample_type smp,
   input  wire cfg_type    cfg,
   input  wire state_type  cur,
   output logic            due,
   output state_type       nxt
);

   logic [31:0] since_check;
   logic [7:0]  qmax;
   logic [31:0] drop_sum;
   logic        drop_seen;
   logic [1:0]  target;
   logic [3:0]  quiet_inc;

   always_comb begin
      // due once the wrapping difference is not negative
      since_check = smp.now_ms - cur.next_check_time;
      due         = ~since_check[31];

      qmax      = (smp.tx_depth > smp.rx_depth) ? smp.tx_depth : smp.rx_depth;
      drop_sum  = smp.tx_drops + smp.rx_drops;
      drop_seen = (drop_sum != cur.previous_drop_sum);

      // severe first, then congested, then busy
      if ((smp.free_buffers <= cfg.severe_free_limit) ||
          (qmax >= cfg.severe_queue_limit)) begin
         target = LVL_SEVERE;
      end else if (drop_seen || (smp.free_buffers <= cfg.congested_free_limit) ||
                   (qmax >= cfg.congested_queue_limit)) begin
         target = LVL_CONGESTED;
      end else if ((smp.free_buffers <= cfg.busy_free_limit) ||
                   (qmax >= cfg.busy_queue_limit)) begin
         target = LVL_BUSY;
      end else begin
         target = LVL_NORMAL;
      end

      quiet_inc = cur.quiet_count + 4'd1;

      nxt                   = cur;
      nxt.previous_drop_sum = drop_sum;
      nxt.next_check_time   = smp.now_ms + {16'd0, cfg.check_interval_ms};

      if (target > cur.current_level) begin
         nxt.current_level = target;
         nxt.quiet_count   = 4'd0;
      end else if (target < cur.current_level) begin
         if (quiet_inc >= cfg.recovery_quiet_count) begin
            nxt.current_level = cur.current_level - 2'd1;
            nxt.quiet_count   = 4'd0;
         end else begin
            nxt.quiet_count = quiet_inc;
         end
      end else begin
         nxt.quiet_count = 4'd0;
      end
   end

endmodule
`default_nettype wire
